[rtl/damped_wave_grid_step_top_macros.svh]
// Assertion helpers for the ripple grid block.
`ifndef DAMPED_WAVE_GRID_STEP_TOP_MACROS_SVH
`define DAMPED_WAVE_GRID_STEP_TOP_MACROS_SVH

// Clocked check that is off while reset is held.
`define DWGS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also looks at the reset cycle.
`define DWGS_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/dwgs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwgs_pkg
// Shared types and constants of the damped wave grid block.
// ----------------------------------------------------------------------------
package dwgs_pkg;

  localparam int H_W    = 24;  // Q11.12 height
  localparam int G_W    = 20;  // Q3.16 gain
  localparam int P_W    = H_W + G_W;
  localparam int ACC_W  = 48;
  localparam int SZ_W   = 11;  // holds any effective grid size
  localparam int CFG_W  = 20;
  localparam int IDX_W  = 3;

  // Commands
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_STEP = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_COLS = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROWS = 3'd1;
  localparam logic [IDX_W-1:0] REG_G1   = 3'd2;
  localparam logic [IDX_W-1:0] REG_G2   = 3'd3;
  localparam logic [IDX_W-1:0] REG_G3   = 3'd4;

  // Gain selects of the multiply-accumulate unit
  localparam logic [1:0] GSEL_CENTER  = 2'd0;
  localparam logic [1:0] GSEL_HISTORY = 2'd1;
  localparam logic [1:0] GSEL_NEIGH   = 2'd2;

  localparam logic signed [H_W-1:0] H_MAX = 24'sh7FFFFF;
  localparam logic signed [H_W-1:0] H_MIN = -24'sh800000;

  typedef struct packed {
    logic       mul_en;
    logic [1:0] gain_sel;
    logic       acc_en;
    logic       acc_load;
  } mac_ctrl_t;

endpackage

[rtl/damped_wave_grid_step_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_wave_grid_step_top
// Damped 2-D wave ripple grid: push, step and read commands on three grids.
// ----------------------------------------------------------------------------
// After reset the block clears all 3*MAX_ROWS*MAX_COLS cells, one per cycle
// (12288 cells at the defaults), with busy high. Push and read fetch the
// cell through the registered read port at the accepting edge and finish
// in ST_WB; the result strobe out_valid then rises with busy dropping at the
// same time. A step scans every interior cell in turn, at a pace set by
// the six reads of the single memory read port and the one shared multiplier
// per cell. A rejected or unused command answers in the cycle right after
// the accepting edge. The result lasts exactly one cycle and cannot be
// stalled. Write configuration only while busy is low.
module damped_wave_grid_step_top #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_cmd,
  input  logic [5:0]                       in_col,
  input  logic [5:0]                       in_row,
  input  logic signed [dwgs_pkg::H_W-1:0]  in_depth,
  input  logic                             in_absolute,
  output logic                             out_valid,
  output logic signed [dwgs_pkg::H_W-1:0]  out_height,
  output logic                             out_status,
  input  logic                             cfg_we,
  input  logic [dwgs_pkg::IDX_W-1:0]       cfg_index,
  input  logic [dwgs_pkg::CFG_W-1:0]       cfg_data
);
  import dwgs_pkg::*;

  `include "damped_wave_grid_step_top_macros.svh"

  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int TOTAL = 3 * CELLS;
  localparam int AW    = $clog2(TOTAL);
  localparam int XW    = $clog2(MAX_COLS);
  localparam int YW    = $clog2(MAX_ROWS);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_WB   = 3'd2;
  localparam logic [2:0] ST_STEP = 3'd3;

  localparam logic [3:0] PH_LAST = 4'd8;

  // Configuration registers
  logic [6:0]            cols_r, rows_r;
  logic signed [G_W-1:0] g1_r, g2_r, g3_r;

  // Sequencer state
  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [1:0]    cur_r, cur_nxt;
  logic [3:0]    ph_r, ph_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [1:0]    cmd_r, cmd_nxt;
  logic signed [H_W-1:0] depth_r, depth_nxt;
  logic          abs_r, abs_nxt;

  logic                  ov_r, ov_nxt;
  logic signed [H_W-1:0] oh_r, oh_nxt;
  logic                  os_r, os_nxt;

  // Memory and unit hookup
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [H_W-1:0]        mem_wdata, mem_rdata;
  logic signed [H_W-1:0] mac_res;
  mac_ctrl_t             mac_ctrl;

  logic [SZ_W-1:0] cols_eff, rows_eff;
  logic [1:0]      prev_g, older_g, new_g;
  logic [AW-1:0]   base_cur, base_prev, base_older, base_new;
  logic [AW-1:0]   step_cell, req_cell;
  logic            in_range, interior, x_last, y_last;
  logic signed [H_W:0] push_sum;
  logic signed [H_W-1:0] push_val;

  function automatic logic [AW-1:0] grid_base(input logic [1:0] g);
    case (g)
      2'd1:    grid_base = AW'(CELLS);
      2'd2:    grid_base = AW'(2 * CELLS);
      default: grid_base = '0;
    endcase
  endfunction

  function automatic logic [SZ_W-1:0] eff_size(input logic [6:0] v, input int maxv);
    if (v < 7'd2) begin
      eff_size = SZ_W'(2);
    end else if (SZ_W'(v) > SZ_W'(maxv)) begin
      eff_size = SZ_W'(maxv);
    end else begin
      eff_size = SZ_W'(v);
    end
  endfunction

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 7'd64;
      rows_r <= 7'd64;
      g1_r   <= 20'sd128164;
      g2_r   <= -20'sd65111;
      g3_r   <= 20'sd621;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLS: cols_r <= cfg_data[6:0];
        REG_ROWS: rows_r <= cfg_data[6:0];
        REG_G1:   g1_r   <= cfg_data;
        REG_G2:   g2_r   <= cfg_data;
        REG_G3:   g3_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Grid sizes, grid roles and cell addresses
  always_comb begin
    cols_eff   = eff_size(cols_r, MAX_COLS);
    rows_eff   = eff_size(rows_r, MAX_ROWS);
    new_g      = (cur_r == 2'd2) ? 2'd0 : cur_r + 2'd1;
    prev_g     = (cur_r == 2'd0) ? 2'd2 : cur_r - 2'd1;
    older_g    = (cur_r == 2'd2) ? 2'd0 : cur_r + 2'd1;
    base_cur   = grid_base(cur_r);
    base_new   = grid_base(new_g);
    base_prev  = grid_base(prev_g);
    base_older = grid_base(older_g);
    step_cell  = AW'(int'(y_r) * MAX_COLS + int'(x_r));
    req_cell   = AW'(int'(in_row) * MAX_COLS + int'(in_col));
    in_range   = (SZ_W'(in_col) < cols_eff) && (SZ_W'(in_row) < rows_eff);
    interior   = (cols_eff > SZ_W'(2)) && (rows_eff > SZ_W'(2));
    x_last     = (SZ_W'(x_r) + SZ_W'(2)) == cols_eff;
    y_last     = (SZ_W'(y_r) + SZ_W'(2)) == rows_eff;
    push_sum   = (H_W+1)'(signed'(mem_rdata)) + (H_W+1)'(depth_r);
    if (push_sum > (H_W+1)'(H_MAX)) begin
      push_val = H_MAX;
    end else if (push_sum < (H_W+1)'(H_MIN)) begin
      push_val = H_MIN;
    end else begin
      push_val = push_sum[H_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cur_nxt   = cur_r;
    ph_nxt    = ph_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    addr_nxt  = addr_r;
    cmd_nxt   = cmd_r;
    depth_nxt = depth_r;
    abs_nxt   = abs_r;
    ov_nxt    = 1'b0;
    oh_nxt    = '0;
    os_nxt    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = '0;
    mem_raddr = '0;
    mac_ctrl  = '0;
    mac_ctrl.gain_sel = GSEL_NEIGH;

    case (state_r)
      ST_CLR: begin
        // Sweep zeros through the store
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(TOTAL - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_raddr = base_cur + req_cell;
        if (start) begin
          cmd_nxt   = in_cmd;
          depth_nxt = in_depth;
          abs_nxt   = in_absolute;
          addr_nxt  = base_cur + req_cell;
          case (in_cmd)
            CMD_STEP: begin
              // Rotate grids, then scan the interior
              cur_nxt = new_g;
              ph_nxt  = '0;
              x_nxt   = XW'(1);
              y_nxt   = YW'(1);
              if (interior) begin
                state_nxt = ST_STEP;
              end else begin
                ov_nxt = 1'b1;
              end
            end
            CMD_PUSH, CMD_READ: begin
              if (in_range) begin
                state_nxt = ST_WB;
              end else begin
                ov_nxt = 1'b1;
                os_nxt = 1'b1;
              end
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_WB: begin
        // Finish push or read with the fetched cell
        ov_nxt = 1'b1;
        if (cmd_r == CMD_READ) begin
          oh_nxt = signed'(mem_rdata);
        end else begin
          mem_we    = 1'b1;
          mem_wdata = abs_r ? depth_r : push_val;
        end
        state_nxt = ST_IDLE;
      end
      ST_STEP: begin
        // Issue the six operand reads
        case (ph_r)
          4'd0:    mem_raddr = base_prev + step_cell;
          4'd1:    mem_raddr = base_older + step_cell;
          4'd2:    mem_raddr = base_prev + step_cell - AW'(1);
          4'd3:    mem_raddr = base_prev + step_cell + AW'(1);
          4'd4:    mem_raddr = base_prev + step_cell - AW'(MAX_COLS);
          4'd5:    mem_raddr = base_prev + step_cell + AW'(MAX_COLS);
          default: mem_raddr = '0;
        endcase
        // Drive the shared unit in the cycle after each read, as its data arrives
        mac_ctrl.mul_en   = (ph_r >= 4'd1) && (ph_r <= 4'd6);
        mac_ctrl.gain_sel = (ph_r == 4'd1) ? GSEL_CENTER :
                            (ph_r == 4'd2) ? GSEL_HISTORY : GSEL_NEIGH;
        mac_ctrl.acc_en   = (ph_r >= 4'd2) && (ph_r <= 4'd7);
        mac_ctrl.acc_load = (ph_r == 4'd2);
        ph_nxt = ph_r + 4'd1;
        if (ph_r == PH_LAST) begin
          // Write the cell and advance
          mem_we    = 1'b1;
          mem_waddr = base_cur + step_cell;
          mem_wdata = mac_res;
          ph_nxt    = '0;
          if (x_last) begin
            x_nxt = XW'(1);
            y_nxt = y_r + YW'(1);
            if (y_last) begin
              ov_nxt    = 1'b1;
              state_nxt = ST_IDLE;
            end
          end else begin
            x_nxt = x_r + XW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold control and request state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r   <= '0;
      cur_r   <= 2'd0;
      ph_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cur_r   <= cur_nxt;
      ph_r    <= ph_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    addr_r  <= addr_nxt;
    cmd_r   <= cmd_nxt;
    depth_r <= depth_nxt;
    abs_r   <= abs_nxt;
    oh_r    <= oh_nxt;
    os_r    <= os_nxt;
  end

  dwgs_mem #(
    .DEPTH(TOTAL),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  dwgs_mac u_mac (
    .clk      (clk),
    .ctrl     (mac_ctrl),
    .din      (signed'(mem_rdata)),
    .g_center (g1_r),
    .g_history(g2_r),
    .g_neigh  (g3_r),
    .result   (mac_res)
  );

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = ov_r;
  assign out_height = oh_r;
  assign out_status = os_r;

  `DWGS_CHECK(a_result_has_cause, out_valid |-> ($past(busy) || $past(start)), "result without request")
  `DWGS_CHECK(a_phase_bound, (state_r == ST_STEP) |-> (ph_r <= PH_LAST), "step phase overrun")
  `DWGS_CHECK(a_write_in_store, mem_we |-> (mem_waddr <= AW'(TOTAL - 1)), "write beyond store")
  `DWGS_CHECK(a_status_no_height, out_status |-> (out_height == '0), "rejected cell carries height")
endmodule

[rtl/dwgs_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwgs_mem
// Height store of all three grids: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dwgs_mem #(
  parameter int DEPTH = 12288,
  parameter int AW    = 14
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [dwgs_pkg::H_W-1:0]    wdata,
  input  logic [AW-1:0]               raddr,
  output logic [dwgs_pkg::H_W-1:0]    rdata
);
  import dwgs_pkg::*;

  logic [H_W-1:0] mem_r [DEPTH];
  logic [H_W-1:0] rdata_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read one entry, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

[rtl/dwgs_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwgs_mac
// Shared multiply-accumulate unit with Q16 rounding and 24-bit saturation.
// ----------------------------------------------------------------------------
module dwgs_mac (
  input  logic                              clk,
  input  dwgs_pkg::mac_ctrl_t               ctrl,
  input  logic signed [dwgs_pkg::H_W-1:0]   din,
  input  logic signed [dwgs_pkg::G_W-1:0]   g_center,
  input  logic signed [dwgs_pkg::G_W-1:0]   g_history,
  input  logic signed [dwgs_pkg::G_W-1:0]   g_neigh,
  output logic signed [dwgs_pkg::H_W-1:0]   result
);
  import dwgs_pkg::*;

  logic signed [G_W-1:0]   gain;
  logic signed [P_W-1:0]   prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-17:0] shr;

  // Pick the gain for this operand
  always_comb begin
    case (ctrl.gain_sel)
      GSEL_CENTER:  gain = g_center;
      GSEL_HISTORY: gain = g_history;
      default:      gain = g_neigh;
    endcase
  end

  // Multiply into prod_r, then accumulate prod_r in the cycle after
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= din * gain;
    end
    if (ctrl.acc_en) begin
      if (ctrl.acc_load) begin
        acc_r <= ACC_W'(prod_r);
      end else begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  // Round half up to Q11.12 and saturate
  always_comb begin
    rnd = acc_r + ACC_W'(32768);
    shr = rnd[ACC_W-1:16];
    if (shr > (ACC_W-16)'(H_MAX)) begin
      result = H_MAX;
    end else if (shr < (ACC_W-16)'(H_MIN)) begin
      result = H_MIN;
    end else begin
      result = shr[H_W-1:0];
    end
  end
endmodule

[verif/damped_wave_grid_step_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_wave_grid_step_top_test
// Self-checking bench for the ripple grid block. A queue of push, step and
// read requests feeds a clocked driver; a clocked monitor predicts every
// result from its own copy of the three grids and compares field by field.
// The run walks through several grid sizes and gain settings, extremes too.
// ----------------------------------------------------------------------------
module damped_wave_grid_step_top_test;
  import dwgs_pkg::*;

  localparam int NCOLS = 64;
  localparam int NROWS = 64;
  localparam int NCELLS = NCOLS * NROWS;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct {
    logic [1:0]            cmd;
    logic [5:0]            col;
    logic [5:0]            row;
    logic signed [H_W-1:0] depth;
    logic                  absolute;
    int                    gap;
    bit                    drain;
  } ripple_req_t;

  typedef struct {
    logic signed [H_W-1:0] height;
    logic                  status;
  } ripple_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_cmd = '0;
  logic [5:0] in_col = '0;
  logic [5:0] in_row = '0;
  logic signed [H_W-1:0] in_depth = '0;
  logic in_absolute = 1'b0;
  logic out_valid;
  logic signed [H_W-1:0] out_height;
  logic out_status;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  damped_wave_grid_step_top #(.MAX_COLS(NCOLS), .MAX_ROWS(NROWS)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_col(in_col), .in_row(in_row), .in_depth(in_depth),
    .in_absolute(in_absolute), .out_valid(out_valid), .out_height(out_height),
    .out_status(out_status), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow grids and settings
  logic signed [H_W-1:0] ripple_mem [3][NCELLS];
  int unsigned live_grid;
  logic [6:0] shadow_cols, shadow_rows;
  logic signed [G_W-1:0] shadow_g1, shadow_g2, shadow_g3;

  ripple_req_t pending_reqs[$];
  ripple_rsp_t expected_rsps[$];
  int error_count = 0;
  int idle_cnt = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  function automatic int grid_extent(input logic [6:0] v);
    if (v < 2) return 2;
    if (v > 64) return 64;
    return int'(v);
  endfunction

  function automatic logic signed [H_W-1:0] clamp_height(input longint v);
    if (v > 64'sd8388607) return H_MAX;
    if (v < -64'sd8388608) return H_MIN;
    return v[H_W-1:0];
  endfunction

  // Advance the rotation and recompute the interior of the new grid
  task automatic advance_ripple();
    int cols, rows, dst, prv, old, c;
    longint nsum, acc;
    cols = grid_extent(shadow_cols);
    rows = grid_extent(shadow_rows);
    live_grid = (live_grid + 1) % 3;
    dst = live_grid;
    prv = (live_grid + 2) % 3;
    old = (live_grid + 1) % 3;
    for (int y = 1; y + 1 < rows; y++) begin
      for (int x = 1; x + 1 < cols; x++) begin
        c = y * NCOLS + x;
        nsum = longint'(ripple_mem[prv][c-1]) + longint'(ripple_mem[prv][c+1])
             + longint'(ripple_mem[prv][c-NCOLS]) + longint'(ripple_mem[prv][c+NCOLS]);
        acc = longint'(shadow_g1) * longint'(ripple_mem[prv][c])
            + longint'(shadow_g2) * longint'(ripple_mem[old][c])
            + longint'(shadow_g3) * nsum;
        ripple_mem[dst][c] = clamp_height((acc + 64'sd32768) >>> 16);
      end
    end
  endtask

  // Apply one request to the shadow state and return its result
  task automatic predict_ripple(input ripple_req_t r, output ripple_rsp_t rsp);
    int c;
    rsp.height = '0;
    rsp.status = 1'b0;
    if (r.cmd == CMD_STEP) begin
      advance_ripple();
    end else if (r.cmd == CMD_PUSH || r.cmd == CMD_READ) begin
      if (r.col >= grid_extent(shadow_cols) || r.row >= grid_extent(shadow_rows)) begin
        rsp.status = 1'b1;
      end else begin
        c = int'(r.row) * NCOLS + int'(r.col);
        if (r.cmd == CMD_READ) rsp.height = ripple_mem[live_grid][c];
        else if (r.absolute) ripple_mem[live_grid][c] = r.depth;
        else ripple_mem[live_grid][c] =
          clamp_height(longint'(ripple_mem[live_grid][c]) + longint'(r.depth));
      end
    end
  endtask

  // Driver: present the next request once its gap has run out and, for a draining request, no result is outstanding
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      idle_cnt <= 0;
    end else if (!(start && busy)) begin
      if (pending_reqs.size() != 0 && idle_cnt >= pending_reqs[0].gap &&
          (!pending_reqs[0].drain || (!start && expected_rsps.size() == 0))) begin
        ripple_req_t nx;
        nx = pending_reqs.pop_front();
        start <= 1'b1;
        in_cmd <= nx.cmd;
        in_col <= nx.col;
        in_row <= nx.row;
        in_depth <= nx.depth;
        in_absolute <= nx.absolute;
        idle_cnt <= 0;
      end else begin
        start <= 1'b0;
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  // Monitor: check results, then predict for the request taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      ripple_req_t r;
      ripple_rsp_t e;
      if (out_valid) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          e = expected_rsps.pop_front();
          if (out_height !== e.height)
            report_mismatch($sformatf("height %0d, want %0d", out_height, e.height));
          if (out_status !== e.status)
            report_mismatch($sformatf("status %0b, want %0b", out_status, e.status));
        end
      end
      if (start && !busy) begin
        r.cmd = in_cmd;
        r.col = in_col;
        r.row = in_row;
        r.depth = in_depth;
        r.absolute = in_absolute;
        r.gap = 0;
        r.drain = 1'b0;
        predict_ripple(r, e);
        expected_rsps.push_back(e);
      end
    end
  end

  task automatic add_req(input logic [1:0] cmd, input int col, input int row,
                         input int depth, input bit absolute, input int gap,
                         input bit drain = 1'b0);
    ripple_req_t r;
    r.cmd = cmd;
    r.col = col[5:0];
    r.row = row[5:0];
    r.depth = depth[H_W-1:0];
    r.absolute = absolute;
    r.gap = gap;
    r.drain = drain;
    pending_reqs.push_back(r);
  endtask

  // Sample on the falling edge so the driver and monitor have settled
  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || busy || start)
      @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    case (idx)
      REG_COLS: shadow_cols = val[6:0];
      REG_ROWS: shadow_rows = val[6:0];
      REG_G1:   shadow_g1 = val[G_W-1:0];
      REG_G2:   shadow_g2 = val[G_W-1:0];
      REG_G3:   shadow_g3 = val[G_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_grid(input int cols, input int rows, input int g1, input int g2,
                          input int g3);
    write_reg(REG_COLS, cols);
    write_reg(REG_ROWS, rows);
    write_reg(REG_G1, g1);
    write_reg(REG_G2, g2);
    write_reg(REG_G3, g3);
  endtask

  // Random requests, mostly pushes and reads inside the grid plus steps
  task automatic random_requests(input int n, input int max_gap, input int step_pct);
    int cols, rows, pick, gap, dep;
    cols = grid_extent(shadow_cols);
    rows = grid_extent(shadow_rows);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      dep = ($urandom_range(0, 3) == 0) ? int'($urandom)
                                        : $urandom_range(0, 40000) - 20000;
      if (pick < step_pct)
        add_req(CMD_STEP, $urandom_range(0, 63), $urandom_range(0, 63), dep, 0, gap);
      else if (pick < 55)
        add_req(CMD_PUSH, $urandom_range(0, cols - 1), $urandom_range(0, rows - 1),
                dep, $urandom_range(0, 1), gap);
      else if (pick < 85)
        add_req(CMD_READ, $urandom_range(0, cols - 1), $urandom_range(0, rows - 1),
                dep, $urandom_range(0, 1), gap);
      else if (pick < 92)
        add_req(pick[0] ? CMD_READ : CMD_PUSH, $urandom_range(0, 63),
                $urandom_range(0, 63), dep, $urandom_range(0, 1), gap);
      else
        add_req(CMD_SPARE, $urandom_range(0, 63), $urandom_range(0, 63), dep,
                $urandom_range(0, 1), gap);
    end
  endtask

  initial begin
    live_grid = 0;
    foreach (ripple_mem[g, c]) ripple_mem[g][c] = '0;
    shadow_cols = 7'd64;
    shadow_rows = 7'd64;
    shadow_g1 = 20'sd128164;
    shadow_g2 = -20'sd65111;
    shadow_g3 = 20'sd621;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // Directed: saturation, size edges, unused command, a few steps
    set_grid(8, 6, 128164, -65111, 621);
    add_req(CMD_PUSH, 3, 2, 8388607, 1, 0);
    add_req(CMD_PUSH, 3, 2, 5, 0, 0);
    add_req(CMD_READ, 3, 2, 0, 0, 0);
    add_req(CMD_PUSH, 4, 3, -8388608, 1, 2);
    add_req(CMD_PUSH, 4, 3, -1, 0, 0);
    add_req(CMD_READ, 4, 3, -1, 1, 0);
    add_req(CMD_PUSH, 0, 0, 4096, 0, 1);
    add_req(CMD_PUSH, 7, 5, -4096, 1, 0);
    add_req(CMD_PUSH, 8, 1, 100, 1, 0);
    add_req(CMD_READ, 1, 6, 0, 0, 0);
    add_req(CMD_READ, 63, 63, -1, 1, 3);
    add_req(CMD_SPARE, 2, 2, 1234, 1, 0);
    add_req(CMD_READ, 0, 0, 0, 0, 0);
    add_req(CMD_STEP, 0, 0, 0, 0, 0);
    add_req(CMD_READ, 3, 2, 0, 0, 0);
    add_req(CMD_STEP, 63, 63, 0, 1, 4, 1'b1);
    add_req(CMD_READ, 2, 2, 0, 0, 0);
    add_req(CMD_READ, 4, 3, 0, 0, 0);
    add_req(CMD_STEP, 0, 0, 0, 0, 0);
    add_req(CMD_READ, 7, 5, 0, 0, 0);
    add_req(CMD_READ, 3, 3, 0, 0, 6);
    wait_idle();

    // Random phases over sizes and gains
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_grid(0, 1, 524287, 524287, 524287);
        1: set_grid(127, 65, 128164, -65111, 621);
        2: set_grid(5, 13, -524288, -524288, -524288);
        default: set_grid($urandom_range(3, 12), $urandom_range(3, 12),
                          $urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF),
                          $urandom_range(0, 20'hFFFFF));
      endcase
      random_requests(10, (p % 2) ? 0 : 6, (p == 1) ? 4 : 18);
      add_req(CMD_READ, $urandom_range(0, 3), $urandom_range(0, 3), 0, 0, 2, 1'b1);
      random_requests(10, (p % 2) ? 6 : 0, (p == 1) ? 4 : 18);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #100ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
